/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the range minimum segment tree RTL.
// Both macros need clk_i in scope; RMST_ASSERT also needs rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define RMST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RMST_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/rmst_pkg.sv */
// Types and constants of the range minimum segment tree core.
// Used by the controller, the datapath and the top level; depends on nothing.
package rmst_pkg;

  localparam int unsigned MaxLeaves = 128;
  localparam int unsigned NodeW     = $clog2(2 * MaxLeaves);
  localparam int unsigned IdxW      = NodeW + 1;
  localparam int unsigned CountW    = 8;
  localparam int unsigned ValueW    = 60;

  localparam logic [ValueW-1:0] Sentinel = 60'd1000000000000000000;

  localparam logic OpSet   = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic              operation;
    logic              tree_select;
    logic [6:0]        position;
    logic [ValueW-1:0] new_value;
    logic [7:0]        range_low;
    logic [7:0]        range_high;
  } rmst_cmd_t;

  typedef struct packed {
    logic [ValueW-1:0] min_value;
    logic              status;
  } rmst_result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_LEAF,
    S_SET_READ,
    S_SET_WRITE,
    S_Q_LEFT,
    S_Q_RIGHT,
    S_DONE
  } rmst_state_e;

  typedef struct packed {
    logic load;
    logic clear_step;
    logic set_leaf;
    logic set_read;
    logic set_write;
    logic q_left;
    logic q_right;
  } rmst_ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic bad;
    logic is_query;
    logic l_lt_r;
    logic p_gt1;
    logic parent_gt1;
  } rmst_stat_t;

endpackage

/* hw/rtl/range_min_segment_tree_core.sv */
// Top level of the range minimum segment tree core: controller plus datapath.
// Depends on rmst_pkg, rmst_ctrl and rmst_datapath.
//
//   channel   ports                     handshake
//   command   cmd_i, start, busy        taken when start && !busy
//   result    result_o, done_o          valid for the one cycle done_o is high
//   config    cfg_we_i, cfg_wdata_i     written when cfg_we_i is high
//
// After reset a clearing pass writes the sentinel to all 2**TreeW * 256 nodes
// while busy is high; config writes are taken meanwhile.
// A set word writes the leaf, then for each of its A ancestors (7 at 128 leaves)
// reads a sibling and writes the ancestor; a query word runs I <= 8 walk iterations.
// Both walks share the single node memory port: one read or write a cycle.
// A rejected word goes straight to done. The result cannot be stalled by the receiver.
module range_min_segment_tree_core #(
  parameter int unsigned TREE_COUNT = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rmst_pkg::rmst_cmd_t    cmd_i,
  input  logic                   start,
  output logic                   busy,
  output rmst_pkg::rmst_result_t result_o,
  output logic                   done_o,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i
);
  import rmst_pkg::*;

  rmst_ctrl_t ctrl;
  rmst_stat_t stat;

  rmst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctrl_o (ctrl),
    .stat_i (stat)
  );

  rmst_datapath #(
    .TREE_COUNT (TREE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .result_o    (result_o)
  );

endmodule

/* hw/rtl/rmst_ctrl.sv */
// Controller of the range minimum segment tree core: sequences the clear pass,
// the leaf update walk and the query walk. Depends on rmst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output rmst_pkg::rmst_ctrl_t ctrl_o,
  input  rmst_pkg::rmst_stat_t stat_i
);
  import rmst_pkg::*;

  rmst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (stat_i.bad) begin
            state_d = S_DONE;
          end else if (stat_i.is_query) begin
            state_d = S_Q_LEFT;
          end else begin
            state_d = S_SET_LEAF;
          end
        end
      end
      S_SET_LEAF:  state_d = stat_i.p_gt1 ? S_SET_READ : S_DONE;
      S_SET_READ:  state_d = S_SET_WRITE;
      S_SET_WRITE: state_d = stat_i.parent_gt1 ? S_SET_READ : S_DONE;
      S_Q_LEFT:    state_d = stat_i.l_lt_r ? S_Q_RIGHT : S_DONE;
      S_Q_RIGHT:   state_d = S_Q_LEFT;
      S_DONE:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.load       = (state_q == S_IDLE) && start;
    ctrl_o.clear_step = (state_q == S_CLEAR);
    ctrl_o.set_leaf   = (state_q == S_SET_LEAF);
    ctrl_o.set_read   = (state_q == S_SET_READ);
    ctrl_o.set_write  = (state_q == S_SET_WRITE);
    ctrl_o.q_left     = (state_q == S_Q_LEFT);
    ctrl_o.q_right    = (state_q == S_Q_RIGHT);
    busy              = (state_q != S_IDLE);
    done_o            = (state_q == S_DONE);
  end

  // An accepted word always keeps the core busy until its result is out.
  `RMST_ASSERT(a_load_then_busy, ctrl_o.load |=> busy, "accepted word did not start work")
  // A result is followed by an idle cycle, so each word yields one strobe.
  `RMST_ASSERT(a_done_then_idle, done_o |=> !busy && !done_o, "result strobe repeated")

endmodule

/* hw/rtl/rmst_datapath.sv */
// Datapath of the range minimum segment tree core: leaf count register, input checks,
// node memory, walk indexes and the minimum unit. Depends on rmst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmst_datapath #(
  parameter int unsigned TREE_COUNT = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rmst_pkg::rmst_cmd_t    cmd_i,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  rmst_pkg::rmst_ctrl_t   ctrl_i,
  output rmst_pkg::rmst_stat_t   stat_o,
  output rmst_pkg::rmst_result_t result_o
);
  import rmst_pkg::*;

  localparam int unsigned TreeW = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1;
  localparam int unsigned AddrW = TreeW + NodeW;
  localparam int unsigned Depth = 2 ** AddrW;

  logic [CountW-1:0] leaf_count_q, leaf_count_d;
  logic [AddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic              rd_pend_q;
  logic              bad_q, bad_d;
  logic              is_query_q, is_query_d;
  logic [TreeW-1:0]  tree_q, tree_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [IdxW-1:0]   l_q, l_d;
  logic [IdxW-1:0]   r_q, r_d;
  logic [ValueW-1:0] rdata_q;
  logic [ValueW-1:0] mem_q [Depth];

  logic              tree_bad, pos_bad, rng_bad, in_bad;
  logic [ValueW-1:0] val_clamped;
  logic [ValueW-1:0] min_w;
  logic              l_lt_r;
  logic              mem_we, mem_re;
  logic [NodeW-1:0]  mem_node;
  logic [AddrW-1:0]  mem_addr;
  logic [ValueW-1:0] mem_wdata;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      leaf_count_d = CountW'(1);
    end else if (cfg_wdata_i > CountW'(MaxLeaves)) begin
      leaf_count_d = CountW'(MaxLeaves);
    end else begin
      leaf_count_d = cfg_wdata_i;
    end
  end

  always_comb begin
    tree_bad    = 32'(cmd_i.tree_select) >= 32'(TREE_COUNT);
    pos_bad     = {1'b0, cmd_i.position} >= leaf_count_q;
    rng_bad     = (cmd_i.range_high > leaf_count_q) || (cmd_i.range_low > cmd_i.range_high);
    in_bad      = tree_bad || ((cmd_i.operation == OpSet) ? pos_bad : rng_bad);
    val_clamped = (cmd_i.new_value > Sentinel) ? Sentinel : cmd_i.new_value;
    min_w       = (rdata_q < acc_q) ? rdata_q : acc_q;
    l_lt_r      = l_q < r_q;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_node  = l_q[NodeW-1:0];
    mem_wdata = acc_q;
    mem_addr  = {tree_q, mem_node};
    if (ctrl_i.clear_step) begin
      mem_we    = 1'b1;
      mem_wdata = Sentinel;
      mem_addr  = clr_cnt_q;
    end else if (ctrl_i.set_leaf) begin
      mem_we = 1'b1;
    end else if (ctrl_i.set_read) begin
      mem_re   = 1'b1;
      mem_node = {l_q[NodeW-1:1], ~l_q[0]};
      mem_addr = {tree_q, mem_node};
    end else if (ctrl_i.set_write) begin
      mem_we    = 1'b1;
      mem_node  = l_q[NodeW:1];
      mem_wdata = min_w;
      mem_addr  = {tree_q, mem_node};
    end else if (ctrl_i.q_left) begin
      mem_re = l_lt_r && l_q[0];
    end else if (ctrl_i.q_right) begin
      mem_re   = r_q[0];
      mem_node = {r_q[NodeW-1:1], 1'b0};
      mem_addr = {tree_q, mem_node};
    end
  end

  always_comb begin
    bad_d      = bad_q;
    is_query_d = is_query_q;
    tree_d     = tree_q;
    acc_d      = acc_q;
    l_d        = l_q;
    r_d        = r_q;
    clr_cnt_d  = clr_cnt_q;
    if (ctrl_i.clear_step) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
    end
    if (ctrl_i.load) begin
      bad_d      = in_bad;
      is_query_d = (cmd_i.operation == OpQuery);
      tree_d     = TreeW'(cmd_i.tree_select);
      if (cmd_i.operation == OpQuery) begin
        acc_d = Sentinel;
        l_d   = IdxW'(cmd_i.range_low) + IdxW'(leaf_count_q);
      end else begin
        acc_d = val_clamped;
        l_d   = IdxW'(cmd_i.position) + IdxW'(leaf_count_q);
      end
      r_d = IdxW'(cmd_i.range_high) + IdxW'(leaf_count_q);
    end else begin
      if (rd_pend_q) acc_d = min_w;
      if (ctrl_i.set_write) begin
        l_d = l_q >> 1;
      end else if (ctrl_i.q_left && l_lt_r && l_q[0]) begin
        l_d = l_q + IdxW'(1);
      end else if (ctrl_i.q_right) begin
        l_d = l_q >> 1;
        r_d = r_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= CountW'(MaxLeaves);
      clr_cnt_q    <= '0;
      rd_pend_q    <= 1'b0;
      bad_q        <= 1'b0;
      is_query_q   <= 1'b0;
    end else begin
      if (cfg_we_i) leaf_count_q <= leaf_count_d;
      clr_cnt_q  <= clr_cnt_d;
      rd_pend_q  <= mem_re;
      bad_q      <= bad_d;
      is_query_q <= is_query_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tree_q <= tree_d;
    acc_q  <= acc_d;
    l_q    <= l_d;
    r_q    <= r_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_addr];
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clear_last = (clr_cnt_q == AddrW'(Depth - 1));
    stat_o.bad        = in_bad;
    stat_o.is_query   = (cmd_i.operation == OpQuery);
    stat_o.l_lt_r     = l_lt_r;
    stat_o.p_gt1      = (l_q[IdxW-1:1] != '0);
    stat_o.parent_gt1 = (l_q[IdxW-1:2] != '0);
    result_o.min_value = (bad_q || !is_query_q) ? '0 : acc_q;
    result_o.status    = bad_q;
  end

  // The walk never writes a parent above the root.
  `RMST_ASSERT(a_parent_not_root, ctrl_i.set_write |-> l_q[IdxW-1:1] != '0, "parent write past root")
  // Stored values are clamped, so no result exceeds the sentinel.
  `RMST_ASSERT_ALWAYS(a_result_bound, result_o.min_value <= Sentinel, "result above sentinel")

endmodule
